### design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the LRU key/value cache
// Sizes, request and response layouts, the entry record held by each cell,
// and the control bundle that the top level broadcasts along the cell chain.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	// Capacity register and fill counter widths.
	localparam int CAP_W  = 5;
	localparam int FILL_W = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

	// Operation codes.
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic                         cmd;
		logic signed [KEY_BITS-1:0]   key;
		logic signed [VALUE_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic                         hit;
		logic signed [VALUE_BITS-1:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic                  valid;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

	// Broadcast to every cell for the request being accepted.
	typedef struct packed {
		logic go;     // the request changes the order of the chain
		logic hit;    // the key is held somewhere in the chain
		logic evict;  // a new key pushes the oldest entry out
	} cell_ctrl_t;

endpackage

### design/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell: one position of the recency-ordered entry chain
// Holds a single entry, compares it against the requested key, and takes the
// entry of its more recent neighbour when the chain shifts through it.
// ----------------------------------------------------------------------------
module lkv_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lkv_pkg::KEY_BITS-1:0] key,
	input  lkv_pkg::cell_ctrl_t          ctrl,
	input  lkv_pkg::entry_t              prev,
	input  logic                         match_after_in,
	output logic                         match_after_out,
	output logic                         match,
	output lkv_pkg::entry_t              ent
);
	import lkv_pkg::*;

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  shift;

	assign match           = valid_q && (key_q == key);
	assign match_after_out = match || match_after_in;

	// A hit moves the matching entry to the head, so every cell from the head
	// down to the match shifts. A new key shifts the whole valid prefix, one
	// cell further when the chain grows.
	always_comb begin
		if (ctrl.hit) begin
			shift = ctrl.go && match_after_out;
		end else if (ctrl.evict) begin
			shift = ctrl.go && valid_q;
		end else begin
			shift = ctrl.go && (valid_q || prev.valid);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

	assign ent = '{valid: valid_q, key: key_q, value: value_q};

endmodule

### design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache, LRU replacement
// A chain of cells kept in recency order, head most recent, answering get and
// put requests with one response each.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload | accepted when
//  --------+-------------------------+---------+-------------------------------
//  in      | in_valid / in_stall     | in_req  | in_valid high, in_stall low
//  out     | out_valid / out_stall   | out_rsp | out_valid high, out_stall low
//  config  | psel penable pwrite     | pwdata  | psel, penable, pwrite, pready
//
// Each request is looked up and applied to the chain in the cycle it is
// accepted; its response appears in the output register the cycle after, so
// one request per cycle is taken while the output side keeps up. The cost of
// a request is set by the combinational key compare across all cells and the
// shift of the chain that follows it. in_stall is raised only while a response
// is held in the output register and out_stall is high. Reset empties the
// chain at once (valid bits only) and sets capacity to sixteen.
//
module lru_key_value_cache (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  lkv_pkg::req_t                  in_req,
	output logic                           out_valid,
	input  logic                           out_stall,
	output lkv_pkg::rsp_t                  out_rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lkv_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lkv_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lkv_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import lkv_pkg::*;

	logic [CAP_W-1:0]      capacity_q;
	logic [FILL_W-1:0]     fill_q;
	logic                  out_valid_q;
	rsp_t                  out_rsp_q;

	logic                  accept;
	logic                  is_put;
	logic                  hit_any;
	logic                  evict;
	logic [CMP_W-1:0]      cap_eff;
	logic [VALUE_BITS-1:0] hit_value;
	logic [ENTRIES-1:0]    match_vec;
	logic [ENTRIES-1:0]    valid_vec;
	logic [ENTRIES:0]      match_after;
	entry_t                head;
	entry_t                ent [ENTRIES];
	cell_ctrl_t            ctrl;

	// ------------------------------------------------------------------
	// Configuration port. Register index sits above the byte offset.
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(capacity_q) : '0;

	// ------------------------------------------------------------------
	// Request handshake. The output register frees the input side.
	// ------------------------------------------------------------------
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign is_put   = (in_req.cmd == CMD_PUT);

	// Capacity zero behaves as one; anything beyond the chain length is
	// clipped to it.
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(capacity_q) > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end else begin
			cap_eff = CMP_W'(capacity_q);
		end
	end

	// ------------------------------------------------------------------
	// Cell chain. Match information ripples from the tail towards the head
	// so that each cell knows whether the hit lies at or behind it.
	// ------------------------------------------------------------------
	assign match_after[ENTRIES] = 1'b0;
	assign hit_any              = match_after[0];

	always_comb begin
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_vec[i]) begin
				hit_value = hit_value | ent[i].value;
			end
			valid_vec[i] = ent[i].valid;
		end
	end

	// A new key evicts the oldest entry once the chain holds capacity entries.
	assign evict = (CMP_W'(fill_q) >= cap_eff);

	// The head takes the touched or inserted entry; a put always brings its
	// own value, a get hit carries the stored one forward.
	always_comb begin
		head.valid = 1'b1;
		head.key   = in_req.key;
		head.value = (hit_any && !is_put) ? hit_value : in_req.value;
	end

	always_comb begin
		ctrl.go    = accept && (hit_any || is_put);
		ctrl.hit   = hit_any;
		ctrl.evict = evict;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		entry_t prev;
		if (i == 0) begin : g_head
			assign prev = head;
		end else begin : g_body
			assign prev = ent[i-1];
		end

		lkv_cell u_cell (
			.clk             (clk),
			.arst_n          (arst_n),
			.key             (in_req.key),
			.ctrl            (ctrl),
			.prev            (prev),
			.match_after_in  (match_after[i+1]),
			.match_after_out (match_after[i]),
			.match           (match_vec[i]),
			.ent             (ent[i])
		);
	end

	// ------------------------------------------------------------------
	// Fill count: grows only when a new key is added without an eviction.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept && is_put && !hit_any && !evict) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// Response register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_rsp_q.hit        <= hit_any;
			out_rsp_q.read_value <= (hit_any && !is_put) ? hit_value : '1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

`ifndef SYNTHESIS
	// Keys in the chain are unique, so at most one cell can match.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("more than one cell matches the requested key");

	// The valid cells form a prefix whose length is the fill count.
	a_fill_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(fill_q))
		else $error("fill count disagrees with the valid cells");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(fill_q) <= CMP_W'(ENTRIES))
		else $error("fill count exceeds the chain length");

	// A new key below capacity lengthens the chain by one.
	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_put && !hit_any && !evict) |=> (fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("insert without eviction did not grow the chain");
`endif

endmodule
